FILE: rtl/iatsm_pkg.sv
// ============================================================================
// iatsm_pkg
// Shared types and constants for the import slot x64 stub matcher.
// ============================================================================
package iatsm_pkg;

    // default depth of the code range table
    localparam int MAX_RANGES_DEF = 16;

    // field widths
    localparam int WORD_W   = 32;
    localparam int BYTE_W   = 8;
    localparam int RIDX_IN_W = 4;
    localparam int RCNT_W   = 5;
    localparam int CFG_IDX_W = 3;

    // item commands
    localparam logic CMD_LOAD_RANGE = 1'b0;
    localparam logic CMD_TEST_EXPORT = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_OFFSET  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPDIR_OFS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPDIR_SIZE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FUNC_TBL_OFS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FUNC_COUNT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_ENABLE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_COUNT  = 3'd7;

    // stub and header constants
    localparam logic [BYTE_W-1:0] OPC_JMP0   = 8'hff;
    localparam logic [BYTE_W-1:0] OPC_JMP1   = 8'h25;
    localparam logic [1:0]        TYPE_X64   = 2'd2;
    localparam int                STUB_LEN   = 6;
    localparam int                SLOT_BYTES = 8;
    localparam int                EXPDIR_BYTES = 40;
    localparam int                FUNC_SHIFT = 2;

    // controller states, one-hot
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_SCAN  = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;        // write range entry from the inputs
        logic capture;     // latch export entry fields
        logic scan_first;  // start range scan at entry 0
        logic scan_next;   // step to the next range entry
        logic finish;      // fold export result into the match flag
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_go;     // export passes the basic checks, the map is enabled and ranges exist
        logic hit;         // current range contains the export
        logic scan_end;    // current range is the last one in use
    } t_dp_stat;

endpackage

FILE: rtl/iat_slot_x64_stub_matcher_core.sv
// ============================================================================
// iat_slot_x64_stub_matcher_core
// Tells whether an export of the image is an x64 jump stub through a slot.
// ============================================================================
//
//  channel   handshake                 payload
//  -------   -----------------------   ------------------------------------
//  item in   i_start & !o_busy         i_cmd, range and export entry fields
//  result    o_valid (one cycle)       o_is_x64_export
//  config    i_cfg_we                  i_cfg_index, i_cfg_wdata
//
//  A range load leaves the block idle: the next item may follow at once.
//  An export item keeps the block busy through the check state, the scan
//  state over at most min(range_count, MAX_RANGES) range entries, and the
//  done state; the range table has one read port and the scan visits one
//  entry per cycle. The result of an item marked last is registered from
//  the done state and shows as the next item may be taken. The receiver cannot stall the result.
//  Reset is synchronous, active low; range entries hold nothing until loaded.
//
module iat_slot_x64_stub_matcher_core #(
    parameter int MAX_RANGES = iatsm_pkg::MAX_RANGES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic                                i_cmd,
    input  logic [iatsm_pkg::RIDX_IN_W-1:0]     i_range_index,
    input  logic [iatsm_pkg::WORD_W-1:0]        i_range_start_word,
    input  logic [iatsm_pkg::WORD_W-1:0]        i_range_len,
    input  logic [iatsm_pkg::WORD_W-1:0]        i_export_offset,
    input  logic [iatsm_pkg::BYTE_W-1:0]        i_stub_byte0,
    input  logic [iatsm_pkg::BYTE_W-1:0]        i_stub_byte1,
    input  logic signed [iatsm_pkg::WORD_W-1:0] i_stub_disp,
    input  logic                                i_last,
    output logic                                o_valid,
    output logic                                o_is_x64_export,
    input  logic                                i_cfg_we,
    input  logic [iatsm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [iatsm_pkg::WORD_W-1:0]        i_cfg_wdata
);
    import iatsm_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    iatsm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_cmd     (i_cmd),
        .o_busy    (o_busy),
        .o_dp_cmd  (dp_cmd),
        .i_dp_stat (dp_stat)
    );

    iatsm_dp #(
        .MAX_RANGES (MAX_RANGES)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_range_index      (i_range_index),
        .i_range_start_word (i_range_start_word),
        .i_range_len        (i_range_len),
        .i_export_offset    (i_export_offset),
        .i_stub_byte0       (i_stub_byte0),
        .i_stub_byte1       (i_stub_byte1),
        .i_stub_disp        (i_stub_disp),
        .i_last             (i_last),
        .i_dp_cmd           (dp_cmd),
        .o_dp_stat          (dp_stat),
        .o_valid            (o_valid),
        .o_is_x64_export    (o_is_x64_export)
    );

    // a result only follows an export item in flight
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(o_busy))
        else $error("result strobe without an export item in flight");

    // an export item always occupies the block
    a_export_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_cmd == CMD_TEST_EXPORT) |=> o_busy)
        else $error("export item accepted but block not busy");

    // a range load finishes at once and makes no result
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_cmd == CMD_LOAD_RANGE) |=> (!o_busy && !o_valid))
        else $error("range load left the block busy or made a result");

    // datapath commands never overlap
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({dp_cmd.load, dp_cmd.capture, dp_cmd.scan_first,
                  dp_cmd.scan_next, dp_cmd.finish}))
        else $error("overlapping datapath commands");

endmodule

FILE: rtl/iatsm_ctrl.sv
// ============================================================================
// iatsm_ctrl
// Sequencer: accepts items, walks the range scan, closes each export item.
// ============================================================================
module iatsm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_cmd,
    output logic                o_busy,
    output iatsm_pkg::t_dp_cmd  o_dp_cmd,
    input  iatsm_pkg::t_dp_stat i_dp_stat
);
    import iatsm_pkg::*;

    t_state r_state, n_state;
    logic   accept;

    assign accept = i_start && (r_state == S_IDLE);
    assign o_busy = (r_state != S_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_cmd == CMD_TEST_EXPORT) n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = i_dp_stat.scan_go ? S_SCAN : S_DONE;
            end
            S_SCAN: begin
                if (i_dp_stat.hit || i_dp_stat.scan_end) n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath commands
    always_comb begin
        o_dp_cmd.load       = accept && (i_cmd == CMD_LOAD_RANGE);
        o_dp_cmd.capture    = accept && (i_cmd == CMD_TEST_EXPORT);
        o_dp_cmd.scan_first = (r_state == S_CHECK) && i_dp_stat.scan_go;
        o_dp_cmd.scan_next  = (r_state == S_SCAN) && !i_dp_stat.hit && !i_dp_stat.scan_end;
        o_dp_cmd.finish     = (r_state == S_DONE);
    end

endmodule

FILE: rtl/iatsm_dp.sv
// ============================================================================
// iatsm_dp
// Datapath: config registers, range table, export checks and match flag.
// ============================================================================
module iatsm_dp #(
    parameter int MAX_RANGES = iatsm_pkg::MAX_RANGES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [iatsm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [iatsm_pkg::WORD_W-1:0]        i_cfg_wdata,
    input  logic [iatsm_pkg::RIDX_IN_W-1:0]     i_range_index,
    input  logic [iatsm_pkg::WORD_W-1:0]        i_range_start_word,
    input  logic [iatsm_pkg::WORD_W-1:0]        i_range_len,
    input  logic [iatsm_pkg::WORD_W-1:0]        i_export_offset,
    input  logic [iatsm_pkg::BYTE_W-1:0]        i_stub_byte0,
    input  logic [iatsm_pkg::BYTE_W-1:0]        i_stub_byte1,
    input  logic signed [iatsm_pkg::WORD_W-1:0] i_stub_disp,
    input  logic                                i_last,
    input  iatsm_pkg::t_dp_cmd                  i_dp_cmd,
    output iatsm_pkg::t_dp_stat                 o_dp_stat,
    output logic                                o_valid,
    output logic                                o_is_x64_export
);
    import iatsm_pkg::*;

    localparam int RIDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CNT_W  = (RIDX_W + 1 > RCNT_W) ? RIDX_W + 1 : RCNT_W;
    localparam logic [CNT_W-1:0] MAXR = CNT_W'(MAX_RANGES);

    // configuration registers
    logic [WORD_W-1:0] r_image_size, r_slot_offset, r_expdir_ofs, r_expdir_size;
    logic [WORD_W-1:0] r_func_tbl_ofs, r_func_count;
    logic              r_map_en;
    logic [RCNT_W-1:0] r_range_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_size   <= '0;
            r_slot_offset  <= '0;
            r_expdir_ofs   <= '0;
            r_expdir_size  <= '0;
            r_func_tbl_ofs <= '0;
            r_func_count   <= '0;
            r_map_en       <= 1'b0;
            r_range_count  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IMAGE_SIZE:   r_image_size   <= i_cfg_wdata;
                CFG_SLOT_OFFSET:  r_slot_offset  <= i_cfg_wdata;
                CFG_EXPDIR_OFS:   r_expdir_ofs   <= i_cfg_wdata;
                CFG_EXPDIR_SIZE:  r_expdir_size  <= i_cfg_wdata;
                CFG_FUNC_TBL_OFS: r_func_tbl_ofs <= i_cfg_wdata;
                CFG_FUNC_COUNT:   r_func_count   <= i_cfg_wdata;
                CFG_MAP_ENABLE:   r_map_en       <= i_cfg_wdata[0];
                CFG_RANGE_COUNT:  r_range_count  <= i_cfg_wdata[RCNT_W-1:0];
            endcase
        end
    end

    // header bounds, registered; the user must keep config static while items run, unenforced
    logic r_hdr_ok;
    always_ff @(posedge i_clk) begin
        r_hdr_ok <= ({1'b0, r_slot_offset} + (WORD_W+1)'(SLOT_BYTES) <= {1'b0, r_image_size})
                 && ({1'b0, r_expdir_ofs} + (WORD_W+1)'(EXPDIR_BYTES) <= {1'b0, r_image_size})
                 && (r_func_tbl_ofs != '0) && (r_func_count != '0)
                 && ({2'b0, r_func_tbl_ofs} + {r_func_count, {FUNC_SHIFT{1'b0}}}
                     <= {2'b0, r_image_size});
    end

    // range table
    logic [WORD_W-1:0] r_mem_start [MAX_RANGES];
    logic [WORD_W-1:0] r_mem_len   [MAX_RANGES];
    logic [WORD_W-1:0] r_rd_start, r_rd_len;
    logic [CNT_W-1:0]  ld_idx;
    logic [CNT_W-1:0]  r_scan_idx;
    logic [CNT_W-1:0]  scan_inc;
    logic [RIDX_W-1:0] rd_addr;

    assign ld_idx   = CNT_W'(i_range_index);
    assign scan_inc = r_scan_idx + CNT_W'(1);
    assign rd_addr  = i_dp_cmd.scan_first ? '0 : scan_inc[RIDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load && (ld_idx < MAXR)) begin
            r_mem_start[ld_idx[RIDX_W-1:0]] <= i_range_start_word;
            r_mem_len[ld_idx[RIDX_W-1:0]]   <= i_range_len;
        end
        if (i_dp_cmd.scan_first || i_dp_cmd.scan_next) begin
            r_rd_start <= r_mem_start[rd_addr];
            r_rd_len   <= r_mem_len[rd_addr];
        end
    end

    // scan position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_idx <= '0;
        end else if (i_dp_cmd.scan_first) begin
            r_scan_idx <= '0;
        end else if (i_dp_cmd.scan_next) begin
            r_scan_idx <= scan_inc;
        end
    end

    // export entry capture
    logic [WORD_W-1:0]        r_addr;
    logic [BYTE_W-1:0]        r_b0, r_b1;
    logic signed [WORD_W-1:0] r_disp;
    logic                     r_last;

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.capture) begin
            r_addr <= i_export_offset;
            r_b0   <= i_stub_byte0;
            r_b1   <= i_stub_byte1;
            r_disp <= i_stub_disp;
            r_last <= i_last;
        end
    end

    // basic export checks, all but the native range test
    logic        in_image, is_fwd, opc_ok, tgt_ok, prelim;
    logic [WORD_W+1:0] target;
    logic [CNT_W-1:0]  n_ranges;

    assign in_image = (r_addr != '0)
                   && ({1'b0, r_addr} + (WORD_W+1)'(STUB_LEN) <= {1'b0, r_image_size});
    assign is_fwd   = (r_addr >= r_expdir_ofs)
                   && ({1'b0, r_addr} < {1'b0, r_expdir_ofs} + {1'b0, r_expdir_size});
    assign opc_ok   = (r_b0 == OPC_JMP0) && (r_b1 == OPC_JMP1);
    assign target   = {2'b0, r_addr} + (WORD_W+2)'(STUB_LEN)
                    + {{2{r_disp[WORD_W-1]}}, r_disp};
    assign tgt_ok   = (target == {2'b0, r_slot_offset});
    assign prelim   = in_image && !is_fwd && opc_ok && tgt_ok;
    assign n_ranges = (CNT_W'(r_range_count) > MAXR) ? MAXR : CNT_W'(r_range_count);

    // basic verdict, follows the captured entry from the check state on
    logic r_prelim;
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.capture) begin
            r_prelim <= 1'b0;
        end else begin
            r_prelim <= prelim;
        end
    end

    // range containment for the entry just read
    logic [WORD_W-1:0] rng_base;
    assign rng_base = {r_rd_start[WORD_W-1:2], 2'b00};

    always_comb begin
        o_dp_stat.scan_go  = prelim && r_map_en && (n_ranges != '0);
        o_dp_stat.hit      = (r_addr >= rng_base) && ((r_addr - rng_base) < r_rd_len);
        o_dp_stat.scan_end = (scan_inc == n_ranges);
    end

    // scan window marker
    logic r_scan_active;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_active <= 1'b0;
        end else if (i_dp_cmd.scan_first) begin
            r_scan_active <= 1'b1;
        end else if (!i_dp_cmd.scan_next) begin
            r_scan_active <= 1'b0;
        end
    end

    // native flag: set when the first containing range is not x64
    logic r_native;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_native <= 1'b0;
        end else if (i_dp_cmd.capture) begin
            r_native <= 1'b0;
        end else if (!i_dp_cmd.finish && !i_dp_cmd.scan_first && !i_dp_cmd.scan_next
                     && o_dp_stat.hit && r_scan_active) begin
            r_native <= (r_rd_start[1:0] != TYPE_X64);
        end
    end

    // match flag and result
    logic r_match_found, r_valid, r_result, item_match;
    assign item_match = r_prelim && !r_native;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_found <= 1'b0;
            r_valid       <= 1'b0;
        end else begin
            r_valid <= i_dp_cmd.finish && r_last;
            if (i_dp_cmd.finish) begin
                r_match_found <= r_last ? 1'b0 : (r_match_found || item_match);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.finish) begin
            r_result <= r_hdr_ok && (r_match_found || item_match);
        end
    end

    assign o_valid         = r_valid;
    assign o_is_x64_export = r_result;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking bench for the import slot x64 stub matcher core. Loads the
// code range table, streams export entries under several header settings
// and compares every verdict against an in-bench model of the matcher.
// ============================================================================
module tb;
    import iatsm_pkg::*;

    localparam int MAXR       = MAX_RANGES_DEF;
    localparam int SETTLE_CYC = 3 + MAXR + 13;   // export latency plus margin
    localparam int STALL_MAX  = 1000;
    localparam int RAND_PER_PHASE = 165;

    typedef struct {
        logic                     cmd;
        logic [RIDX_IN_W-1:0]     ridx;
        logic [WORD_W-1:0]        rword;
        logic [WORD_W-1:0]        rlen;
        logic [WORD_W-1:0]        eofs;
        logic [BYTE_W-1:0]        b0;
        logic [BYTE_W-1:0]        b1;
        logic signed [WORD_W-1:0] disp;
        logic                     last;
    } t_entry;

    typedef struct {
        logic [WORD_W-1:0] img;
        logic [WORD_W-1:0] slot;
        logic [WORD_W-1:0] edo;
        logic [WORD_W-1:0] eds;
        logic [WORD_W-1:0] fto;
        logic [WORD_W-1:0] fc;
        logic              map;
        logic [RCNT_W-1:0] rcnt;
    } t_hdr;

    // DUT ports
    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_start = 1'b0;
    logic                     o_busy;
    logic                     i_cmd = 1'b0;
    logic [RIDX_IN_W-1:0]     i_range_index = '0;
    logic [WORD_W-1:0]        i_range_start_word = '0;
    logic [WORD_W-1:0]        i_range_len = '0;
    logic [WORD_W-1:0]        i_export_offset = '0;
    logic [BYTE_W-1:0]        i_stub_byte0 = '0;
    logic [BYTE_W-1:0]        i_stub_byte1 = '0;
    logic signed [WORD_W-1:0] i_stub_disp = '0;
    logic                     i_last = 1'b0;
    logic                     o_valid;
    logic                     o_is_x64_export;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [WORD_W-1:0]        i_cfg_wdata = '0;

    // stimulus and expectation stores
    t_entry      entry_q[$];
    bit          verdict_q[$];
    int          gap_pct = 13;
    int unsigned n_presented = 0;
    int unsigned n_accepted = 0;
    int unsigned n_loads = 0, n_exports = 0, n_verdicts = 0, n_hits = 0;
    int unsigned n_settings = 0;
    int unsigned err_cnt = 0;
    int unsigned stall_cnt = 0;

    // model state: header registers, range table, pending match
    t_hdr              cur = '{default: '0};
    logic [WORD_W-1:0] tbl_start[MAXR];
    logic [WORD_W-1:0] tbl_len[MAXR];
    bit                match_pending = 1'b0;

    // generator-side view of the header and range table
    t_hdr              plan;
    logic [WORD_W-1:0] gen_start[MAXR];
    logic [WORD_W-1:0] gen_len[MAXR];

    iat_slot_x64_stub_matcher_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (i_start),
        .o_busy             (o_busy),
        .i_cmd              (i_cmd),
        .i_range_index      (i_range_index),
        .i_range_start_word (i_range_start_word),
        .i_range_len        (i_range_len),
        .i_export_offset    (i_export_offset),
        .i_stub_byte0       (i_stub_byte0),
        .i_stub_byte1       (i_stub_byte1),
        .i_stub_disp        (i_stub_disp),
        .i_last             (i_last),
        .o_valid            (o_valid),
        .o_is_x64_export    (o_is_x64_export),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wdata        (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Matcher model
    // ------------------------------------------------------------------

    // header sums are taken in 64 bits so nothing wraps
    function automatic bit header_in_bounds();
        longint unsigned img;
        img = 64'(cur.img);
        if (64'(cur.slot) + SLOT_BYTES > img) return 1'b0;
        if (64'(cur.edo) + EXPDIR_BYTES > img) return 1'b0;
        if (cur.fto == '0 || cur.fc == '0) return 1'b0;
        if (64'(cur.fto) + 64'(cur.fc) * 4 > img) return 1'b0;
        return 1'b1;
    endfunction

    // first range holding the address decides; only x64 ranges are not native
    function automatic bit lands_in_native_code(logic [WORD_W-1:0] a);
        int                n;
        logic [WORD_W-1:0] base;
        if (!cur.map) return 1'b0;
        n = (int'(cur.rcnt) > MAXR) ? MAXR : int'(cur.rcnt);
        for (int i = 0; i < n; i++) begin
            base = tbl_start[i] & ~32'h3;
            if (a >= base && a - base < tbl_len[i])
                return tbl_start[i][1:0] != TYPE_X64;
        end
        return 1'b0;
    endfunction

    function automatic bit jumps_through_slot(t_entry e);
        longint signed target;
        if (e.eofs == '0 || 64'(e.eofs) + STUB_LEN > 64'(cur.img)) return 1'b0;
        if (e.eofs >= cur.edo && 64'(e.eofs) < 64'(cur.edo) + 64'(cur.eds)) return 1'b0;
        if (e.b0 != OPC_JMP0 || e.b1 != OPC_JMP1) return 1'b0;
        target = $signed({32'h0, e.eofs}) + STUB_LEN + e.disp;
        if (target != $signed({32'h0, cur.slot})) return 1'b0;
        return !lands_in_native_code(e.eofs);
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents queued items, idles at random between them
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_entry e;
        logic   go;
        go = i_start;
        if (!i_rst_n) begin
            go = 1'b0;
        end else if (!i_start || n_accepted == n_presented) begin
            go = 1'b0;
            if (entry_q.size() > 0 && $urandom_range(99, 0) >= gap_pct) begin
                e = entry_q.pop_front();
                go = 1'b1;
                n_presented = n_presented + 1;
                i_cmd              <= e.cmd;
                i_range_index      <= e.ridx;
                i_range_start_word <= e.rword;
                i_range_len        <= e.rlen;
                i_export_offset    <= e.eofs;
                i_stub_byte0       <= e.b0;
                i_stub_byte1       <= e.b1;
                i_stub_disp        <= e.disp;
                i_last             <= e.last;
            end
        end
        i_start <= go;
    end

    // ------------------------------------------------------------------
    // Monitor: checks verdicts, tracks config writes, predicts on accept
    // ------------------------------------------------------------------
    task automatic flag_error(string what, bit want, logic got);
        err_cnt++;
        if (err_cnt <= 10)
            $display("ERROR %0t: %s expected %0b got %0b", $realtime, what, want, got);
    endtask

    always @(posedge i_clk) begin
        t_entry e;
        bit     want;
        if (i_rst_n) begin
            // verdict from the core
            if (o_valid) begin
                if (verdict_q.size() == 0) begin
                    flag_error("unexpected verdict:", 1'b0, o_is_x64_export);
                end else begin
                    want = verdict_q.pop_front();
                    n_verdicts++;
                    if (want) n_hits++;
                    if (o_is_x64_export !== want)
                        flag_error("is_x64_export:", want, o_is_x64_export);
                end
            end
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_IMAGE_SIZE:   cur.img  = i_cfg_wdata;
                    CFG_SLOT_OFFSET:  cur.slot = i_cfg_wdata;
                    CFG_EXPDIR_OFS:   cur.edo  = i_cfg_wdata;
                    CFG_EXPDIR_SIZE:  cur.eds  = i_cfg_wdata;
                    CFG_FUNC_TBL_OFS: cur.fto  = i_cfg_wdata;
                    CFG_FUNC_COUNT:   cur.fc   = i_cfg_wdata;
                    CFG_MAP_ENABLE:   cur.map  = i_cfg_wdata[0];
                    CFG_RANGE_COUNT:  cur.rcnt = i_cfg_wdata[RCNT_W-1:0];
                    default: ;
                endcase
            end
            // accepted item
            if (i_start && !o_busy) begin
                n_accepted <= n_accepted + 1;
                e.cmd   = i_cmd;
                e.ridx  = i_range_index;
                e.rword = i_range_start_word;
                e.rlen  = i_range_len;
                e.eofs  = i_export_offset;
                e.b0    = i_stub_byte0;
                e.b1    = i_stub_byte1;
                e.disp  = i_stub_disp;
                e.last  = i_last;
                if (e.cmd == CMD_LOAD_RANGE) begin
                    n_loads++;
                    if (int'(e.ridx) < MAXR) begin
                        tbl_start[e.ridx] = e.rword;
                        tbl_len[e.ridx]   = e.rlen;
                    end
                end else begin
                    n_exports++;
                    if (jumps_through_slot(e)) match_pending = 1'b1;
                    if (e.last) begin
                        verdict_q.push_back(header_in_bounds() && match_pending);
                        match_pending = 1'b0;
                    end
                end
            end
        end
    end

    // watchdog: cycles in which neither an item nor a verdict moves
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_start && !o_busy) || o_valid) begin
                stall_cnt <= 0;
            end else if (stall_cnt >= STALL_MAX) begin
                $display("tb failed");
                $finish;
            end else begin
                stall_cnt <= stall_cnt + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Item builders and random generation
    // ------------------------------------------------------------------
    function automatic t_entry mk_load(int idx, logic [31:0] word, logic [31:0] len,
                                       logic last);
        t_entry e;
        e = '{cmd: CMD_LOAD_RANGE, ridx: idx[RIDX_IN_W-1:0], rword: word, rlen: len,
              eofs: $urandom(), b0: BYTE_W'($urandom()), b1: BYTE_W'($urandom()),
              disp: $urandom(), last: last};
        gen_start[idx] = word;
        gen_len[idx]   = len;
        return e;
    endfunction

    function automatic t_entry mk_export(logic [31:0] addr, logic [7:0] b0, logic [7:0] b1,
                                         logic [31:0] disp, logic last);
        t_entry e;
        e = '{cmd: CMD_TEST_EXPORT, ridx: RIDX_IN_W'($urandom()), rword: $urandom(),
              rlen: $urandom(), eofs: addr, b0: b0, b1: b1, disp: disp, last: last};
        return e;
    endfunction

    // range load aimed mostly inside the image
    function automatic t_entry rand_load();
        int          idx;
        logic [31:0] word, len, top;
        idx  = $urandom_range(MAXR - 1, 0);
        top  = (plan.img > 8) ? plan.img - 1 : 32'hFFFF_FFFF;
        word = ($urandom_range(top, 0) & ~32'h3) | $urandom_range(3, 0);
        len  = $urandom_range((top >> 3) + 1, 1);
        case ($urandom_range(9, 0))
            0: len = 32'hFFFF_FFFF;
            1: len = '0;
            2: begin
                word = $urandom();
                len  = $urandom();
            end
            default: ;
        endcase
        return mk_load(idx, word, len, 1'($urandom_range(1, 0)));
    endfunction

    // export entry: mostly well-formed stubs toward the slot, some broken
    function automatic t_entry rand_export();
        int          r, j;
        logic [31:0] addr, disp, span;
        logic [7:0]  b0, b1;
        bit          disp_set;
        disp_set = 1'b0;
        r = $urandom_range(99, 0);
        if (r < 35) begin
            j    = $urandom_range(MAXR - 1, 0);
            span = (gen_len[j] == 0) ? 0 : gen_len[j] - 1;
            addr = (gen_start[j] & ~32'h3) + $urandom_range((span > 32'hFFFF) ? 32'hFFFF : span, 0);
        end else if (r < 60) begin
            addr = $urandom_range((plan.img > 7) ? plan.img - 6 : 1, 1);
        end else if (r < 70) begin
            disp = $signed(32'($urandom_range(32'h1_FFFF, 0))) - 32'sh1_0000;
            addr = plan.slot - STUB_LEN - disp;
            disp_set = 1'b1;
        end else if (r < 78) begin
            span = (plan.eds == 0) ? 0 : plan.eds - 1;
            addr = plan.edo + $urandom_range((span > 32'hFFFF) ? 32'hFFFF : span, 0);
        end else if (r < 86) begin
            case ($urandom_range(6, 0))
                0: addr = '0;
                1: addr = plan.img - 6;
                2: addr = plan.img - 5;
                3: addr = plan.edo + plan.eds;
                4: addr = plan.edo - 1;
                5: addr = 32'hFFFF_FFFF;
                default: addr = 32'hFFFF_FFFA;
            endcase
        end else begin
            addr = $urandom();
        end
        if (!disp_set) begin
            disp = plan.slot - addr - STUB_LEN;
            case ($urandom_range(9, 0))
                0: disp = disp + 1;
                1: disp = disp - 1;
                2: disp = $urandom();
                default: ;
            endcase
        end
        b0 = OPC_JMP0;
        b1 = OPC_JMP1;
        case ($urandom_range(19, 0))
            0: b0 = BYTE_W'($urandom());
            1: b1 = BYTE_W'($urandom());
            2: begin
                b0 = BYTE_W'($urandom());
                b1 = BYTE_W'($urandom());
            end
            default: ;
        endcase
        return mk_export(addr, b0, b1, disp, $urandom_range(5, 0) == 0);
    endfunction

    // header setting for one random phase; kind selects a corner
    function automatic t_hdr rand_setting(int kind);
        t_hdr c;
        c.img  = $urandom_range(32'h0010_0000, 32'h0000_1000);
        c.slot = $urandom_range(c.img - 8, 0) & ~32'h7;
        c.edo  = $urandom_range(c.img - 40, 0);
        c.eds  = $urandom_range(32'h400, 0);
        c.fto  = $urandom_range(c.img - 64, 1);
        c.fc   = $urandom_range((c.img - c.fto) >> 2, 1);
        c.map  = 1'($urandom_range(1, 0));
        c.rcnt = RCNT_W'($urandom_range(MAXR, 1));
        case (kind)
            1: begin
                c.map  = 1'b1;
                c.rcnt = RCNT_W'(MAXR);
            end
            2: begin
                c.map  = 1'b1;
                c.rcnt = RCNT_W'($urandom_range(31, MAXR + 1));
            end
            3: begin
                c.map  = 1'b1;
                c.rcnt = '0;
            end
            4: c.map = 1'b0;
            5: begin
                // everything pushed to the top of the address space
                c.img  = 32'hFFFF_FFFF;
                c.slot = 32'hFFFF_FFF7;
                c.edo  = 32'hFFFF_FFD7;
                c.eds  = 32'hFFFF_FFFF;
                c.fto  = 32'h1;
                c.fc   = 32'h3FFF_FFFF;
            end
            6: begin
                // one header bound broken
                case ($urandom_range(5, 0))
                    0: c.fc = '0;
                    1: c.fto = '0;
                    2: c.slot = c.img - 7;
                    3: c.edo = c.img - 39;
                    4: c.fc = ((c.img - c.fto) >> 2) + 1;
                    default: c.fc = 32'hFFFF_FFFF;
                endcase
            end
            7: c = '{default: '0};
            default: ;
        endcase
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------
    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = val;
    endtask

    task automatic write_setting(t_hdr c);
        plan = c;
        put_reg(CFG_IMAGE_SIZE,   c.img);
        put_reg(CFG_SLOT_OFFSET,  c.slot);
        put_reg(CFG_EXPDIR_OFS,   c.edo);
        put_reg(CFG_EXPDIR_SIZE,  c.eds);
        put_reg(CFG_FUNC_TBL_OFS, c.fto);
        put_reg(CFG_FUNC_COUNT,   c.fc);
        put_reg(CFG_MAP_ENABLE,   32'(c.map));
        put_reg(CFG_RANGE_COUNT,  32'(c.rcnt));
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        n_settings++;
    endtask

    // all items taken, all verdicts in, then room for a trailing export
    task automatic wait_quiet();
        while (entry_q.size() != 0 || i_start || verdict_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    initial begin
        t_hdr        c;
        int          kinds[9];
        logic [31:0] s;
        kinds = '{1, 4, 6, 2, 0, 5, 3, 7, 0};

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: small image, slot at 0x2000, export dir at 0x8000
        c = '{img: 32'h1_0000, slot: 32'h2000, edo: 32'h8000, eds: 32'h100,
              fto: 32'h8100, fc: 32'd16, map: 1'b1, rcnt: 5'(MAXR)};
        write_setting(c);
        s = c.slot;
        // range table: x64, ARM64, EC, type 3, huge x64, shadowed overlap
        entry_q.push_back(mk_load(0, 32'h1000 | TYPE_X64, 32'h1000, 1'b0));
        entry_q.push_back(mk_load(1, 32'h3000, 32'h1000, 1'b0));
        entry_q.push_back(mk_load(2, 32'h4001, 32'h800, 1'b0));
        entry_q.push_back(mk_load(3, 32'h4803, 32'h100, 1'b0));
        entry_q.push_back(mk_load(4, 32'h5000 | TYPE_X64, 32'hFFFF_FFFF, 1'b0));
        entry_q.push_back(mk_load(5, 32'hFFFF_FFFF, 32'h0, 1'b1));  // last is ignored
        entry_q.push_back(mk_load(6, 32'h1000, 32'h2000, 1'b0));
        for (int i = 7; i < MAXR - 1; i++)
            entry_q.push_back(mk_load(i, 32'h0, 32'h0, 1'b0));
        entry_q.push_back(mk_load(MAXR - 1, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 1'b0));
        // exports
        entry_q.push_back(mk_export(32'h1800, OPC_JMP0, OPC_JMP1, s - 32'h1806, 1'b1));
        entry_q.push_back(mk_export(32'h3000, OPC_JMP0, OPC_JMP1, s - 32'h3006, 1'b1));
        entry_q.push_back(mk_export(32'h4100, OPC_JMP0, OPC_JMP1, s - 32'h4106, 1'b0));
        entry_q.push_back(mk_export(32'h4880, OPC_JMP0, OPC_JMP1, s - 32'h4886, 1'b0));
        entry_q.push_back(mk_export(32'h0, OPC_JMP0, OPC_JMP1, s - 32'h6, 1'b1));
        entry_q.push_back(mk_export(32'hFFFA, OPC_JMP0, OPC_JMP1, s - 32'h1_0000, 1'b1));
        entry_q.push_back(mk_export(32'hFFFB, OPC_JMP0, OPC_JMP1, s - 32'h1_0001, 1'b1));
        entry_q.push_back(mk_export(32'h8010, OPC_JMP0, OPC_JMP1, s - 32'h8016, 1'b1));
        entry_q.push_back(mk_export(32'h8100, OPC_JMP0, OPC_JMP1, s - 32'h8106, 1'b1));
        entry_q.push_back(mk_export(32'h0F00, 8'hFE, 8'h24, s - 32'h0F06, 1'b0));
        entry_q.push_back(mk_export(32'h0F00, OPC_JMP0, OPC_JMP1, s - 32'h0F05, 1'b1));
        entry_q.push_back(mk_export(32'h0F00, OPC_JMP0, OPC_JMP1, s - 32'h0F06, 1'b1));
        wait_quiet();

        // directed: stub at the very top of a full-size image, no code map
        c = '{img: 32'hFFFF_FFFF, slot: 32'hFFFF_FFF0, edo: 32'h0, eds: 32'h0,
              fto: 32'h4, fc: 32'h3FFF_FFFE, map: 1'b0, rcnt: '0};
        write_setting(c);
        entry_q.push_back(mk_export(32'hFFFF_FFF9, OPC_JMP0, OPC_JMP1, -32'sd15, 1'b1));
        entry_q.push_back(mk_export(32'hFFFF_FFFA, OPC_JMP0, OPC_JMP1, -32'sd16, 1'b1));
        entry_q.push_back(mk_export(32'h7FFF_FFF0, OPC_JMP0, OPC_JMP1, 32'h7FFF_FFFA, 1'b1));
        wait_quiet();

        // random phases: sender idles lightly, then heavily, then never
        for (int p = 0; p < 9; p++) begin
            gap_pct = (p < 3) ? 13 : (p < 6) ? 82 : 0;
            write_setting(rand_setting(kinds[p]));
            for (int k = 0; k < RAND_PER_PHASE; k++) begin
                if ($urandom_range(99, 0) < 15) entry_q.push_back(rand_load());
                else entry_q.push_back(rand_export());
            end
            wait_quiet();
        end

        $display("covered %0d items (%0d range loads, %0d exports) over %0d header settings",
                 n_accepted, n_loads, n_exports, n_settings);
        $display("checked %0d verdicts, %0d of them matches; %0d mismatches",
                 n_verdicts, n_hits, err_cnt);
        if (err_cnt == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
